// ===== design/gbn_pkg.sv =====
package gbn_pkg;

    localparam int SEQ_BITS     = 2;
    localparam int SEQ_NUM      = 4;
    localparam int CNT_BITS     = 3;
    localparam int CFG_BITS     = 24;
    localparam int WINDOW_DEF   = 4;
    localparam int PAYLOAD_DEF  = 16;
    localparam int TIMER_DEF    = 24;

    localparam logic [CFG_BITS-1:0] TIMEOUT_RST = 24'd8000000;
    localparam logic [SEQ_BITS-1:0] RX_SEQ_RST  = 2'd3;

    // request operation codes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SEND = 2'd1;
    localparam logic [1:0] OP_ACK  = 2'd2;
    localparam logic [1:0] OP_DATA = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_ACK     = 2'd1;
    localparam logic [1:0] KIND_DELIVER = 2'd2;
    localparam logic [1:0] KIND_REFUSE  = 2'd3;

endpackage

// ===== design/gbn_tmr_unit.sv =====
module gbn_tmr_unit #(
    parameter int TIMER_BITS = gbn_pkg::TIMER_DEF
) (
    input  logic [TIMER_BITS-1:0]        i_timer,
    input  logic [gbn_pkg::CFG_BITS-1:0] i_timeout,
    output logic [TIMER_BITS-1:0]        o_timer,
    output logic                         o_expired
);

    localparam int CMP_W = (TIMER_BITS > gbn_pkg::CFG_BITS) ? TIMER_BITS : gbn_pkg::CFG_BITS;

    logic             sat;
    logic [CMP_W-1:0] tmr_ext;
    logic [CMP_W-1:0] lim_ext;

    // saturating increment, then compare against the limit
    assign sat       = &i_timer;
    assign o_timer   = sat ? i_timer : i_timer + TIMER_BITS'(1);
    assign tmr_ext   = CMP_W'(o_timer);
    assign lim_ext   = CMP_W'(i_timeout);
    assign o_expired = tmr_ext > lim_ext;

endmodule

// ===== design/go_back_n_arq_link_core.sv =====
// send and data requests present their first result after the exec state (an in-order
// data frame gives its ack from the ack state after the delivery); acks, and data frames
// that are neither next nor a repeat, give none. tick: a decode, a scan of each
// outstanding slot through the shared timer unit and a final check, then one resend
// per cycle on timeout while the output is free; the input stalls until back in idle
// reset (synchronous, active low) clears window and timers, presets the receive sequence
module go_back_n_arq_link_core #(
    parameter int WINDOW_SIZE  = gbn_pkg::WINDOW_DEF,
    parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_DEF,
    parameter int TIMER_BITS   = gbn_pkg::TIMER_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [gbn_pkg::CFG_BITS-1:0] i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_operation,
    input  logic [gbn_pkg::SEQ_BITS-1:0] i_seq_in,
    input  logic [PAYLOAD_BITS-1:0]      i_payload_in,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_kind,
    output logic [gbn_pkg::SEQ_BITS-1:0] o_seq_out,
    output logic [PAYLOAD_BITS-1:0]      o_payload_out,
    output logic                         o_last
);

    localparam int SB = gbn_pkg::SEQ_BITS;
    localparam int CB = gbn_pkg::CNT_BITS;
    localparam logic [CB-1:0] WIN = CB'(WINDOW_SIZE);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_RESEND = 3'd3;
    localparam logic [2:0] S_ACK2   = 3'd4;

    localparam logic [1:0] OP_TICK_C = gbn_pkg::OP_TICK;
    localparam logic [1:0] OP_SEND_C = gbn_pkg::OP_SEND;
    localparam logic [1:0] OP_ACK_C  = gbn_pkg::OP_ACK;

    logic [2:0]                   r_state, n_state;
    logic [gbn_pkg::CFG_BITS-1:0] r_timeout;
    logic [1:0]                   r_op;
    logic [SB-1:0]                r_seq;
    logic [PAYLOAD_BITS-1:0]      r_pay;
    logic [SB-1:0]                r_next, n_next;
    logic [SB-1:0]                r_oldest, n_oldest;
    logic [CB-1:0]                r_cnt, n_cnt;
    logic [SB-1:0]                r_rx_seq, n_rx_seq;
    logic [CB-1:0]                r_idx, n_idx;
    logic                         r_fire, n_fire;
    logic [TIMER_BITS-1:0]        r_timer [gbn_pkg::SEQ_NUM];
    logic [TIMER_BITS-1:0]        n_timer [gbn_pkg::SEQ_NUM];
    logic [PAYLOAD_BITS-1:0]      r_win_pay [gbn_pkg::SEQ_NUM];

    logic                         r_out_valid, n_out_valid;
    logic [1:0]                   r_kind, n_kind;
    logic [SB-1:0]                r_seq_out, n_seq_out;
    logic [PAYLOAD_BITS-1:0]      r_pay_out, n_pay_out;
    logic                         r_last, n_last;

    logic                         win_we;
    logic                         out_free;
    logic                         emit;
    logic [SB-1:0]                slot;
    logic [SB-1:0]                ack_dist;
    logic [TIMER_BITS-1:0]        tmr_next;
    logic                         tmr_expired;

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_seq_out     = r_seq_out;
    assign o_payload_out = r_pay_out;
    assign o_last        = r_last;

    assign out_free = !r_out_valid || !i_out_stall;
    assign slot     = r_oldest + r_idx[SB-1:0];
    assign ack_dist = r_seq - r_oldest;

    // one timer update per cycle, shared across the slots
    gbn_tmr_unit #(
        .TIMER_BITS(TIMER_BITS)
    ) u_tmr (
        .i_timer  (r_timer[slot]),
        .i_timeout(r_timeout),
        .o_timer  (tmr_next),
        .o_expired(tmr_expired)
    );

    always_comb begin
        n_state   = r_state;
        n_next    = r_next;
        n_oldest  = r_oldest;
        n_cnt     = r_cnt;
        n_rx_seq  = r_rx_seq;
        n_idx     = r_idx;
        n_fire    = r_fire;
        n_timer   = r_timer;
        win_we    = 1'b0;
        emit      = 1'b0;
        n_kind    = r_kind;
        n_seq_out = r_seq_out;
        n_pay_out = r_pay_out;
        n_last    = r_last;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_op)
                    OP_TICK_C: begin
                        n_idx   = '0;
                        n_fire  = 1'b0;
                        n_state = S_SCAN;
                    end
                    OP_SEND_C: begin
                        if (out_free) begin
                            emit      = 1'b1;
                            n_seq_out = r_next;
                            n_pay_out = r_pay;
                            n_last    = 1'b1;
                            n_state   = S_IDLE;
                            if (r_cnt >= WIN) begin
                                n_kind = gbn_pkg::KIND_REFUSE;
                            end else begin
                                n_kind           = gbn_pkg::KIND_DATA;
                                win_we           = 1'b1;
                                n_timer[r_next]  = '0;
                                n_cnt            = r_cnt + CB'(1);
                                n_next           = r_next + SB'(1);
                            end
                        end
                    end
                    OP_ACK_C: begin
                        if (CB'(ack_dist) < r_cnt) begin
                            n_oldest = r_seq + SB'(1);
                            n_cnt    = r_cnt - CB'(ack_dist) - CB'(1);
                        end
                        n_state = S_IDLE;
                    end
                    default: begin
                        if (r_seq == r_rx_seq + SB'(1)) begin
                            if (out_free) begin
                                emit      = 1'b1;
                                n_kind    = gbn_pkg::KIND_DELIVER;
                                n_seq_out = r_seq;
                                n_pay_out = r_pay;
                                n_last    = 1'b0;
                                n_rx_seq  = r_seq;
                                n_state   = S_ACK2;
                            end
                        end else if (r_seq == r_rx_seq) begin
                            if (out_free) begin
                                emit    = 1'b1;
                                n_kind  = gbn_pkg::KIND_ACK;
                                n_seq_out = r_seq;
                                n_pay_out = '0;
                                n_last  = 1'b1;
                                n_state = S_IDLE;
                            end
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                if (r_idx == r_cnt) begin
                    n_idx   = '0;
                    n_state = r_fire ? S_RESEND : S_IDLE;
                end else begin
                    n_timer[slot] = tmr_next;
                    n_fire        = r_fire | tmr_expired;
                    n_idx         = r_idx + CB'(1);
                end
            end
            S_RESEND: begin
                if (out_free) begin
                    emit          = 1'b1;
                    n_kind        = gbn_pkg::KIND_DATA;
                    n_seq_out     = slot;
                    n_pay_out     = r_win_pay[slot];
                    n_last        = (r_idx + CB'(1) == r_cnt);
                    n_timer[slot] = '0;
                    n_idx         = r_idx + CB'(1);
                    if (r_idx + CB'(1) == r_cnt) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ACK2: begin
                if (out_free) begin
                    emit      = 1'b1;
                    n_kind    = gbn_pkg::KIND_ACK;
                    n_seq_out = r_seq;
                    n_pay_out = '0;
                    n_last    = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = out_free ? emit : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_timeout   <= gbn_pkg::TIMEOUT_RST;
            r_next      <= '0;
            r_oldest    <= '0;
            r_cnt       <= '0;
            r_rx_seq    <= gbn_pkg::RX_SEQ_RST;
            r_idx       <= '0;
            r_fire      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < gbn_pkg::SEQ_NUM; k++) begin
                r_timer[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_next      <= n_next;
            r_oldest    <= n_oldest;
            r_cnt       <= n_cnt;
            r_rx_seq    <= n_rx_seq;
            r_idx       <= n_idx;
            r_fire      <= n_fire;
            r_out_valid <= n_out_valid;
            r_timer     <= n_timer;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
        end
    end

    // request and result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_op  <= i_operation;
            r_seq <= i_seq_in;
            r_pay <= i_payload_in;
        end
        if (win_we) begin
            r_win_pay[r_next] <= r_pay;
        end
        if (emit) begin
            r_kind    <= n_kind;
            r_seq_out <= n_seq_out;
            r_pay_out <= n_pay_out;
            r_last    <= n_last;
        end
    end

endmodule

// ===== bench/gbn_link_checker.sv =====
module gbn_link_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [gbn_pkg::CFG_BITS-1:0]   i_cfg_wdata,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [1:0]                     i_operation,
    input  logic [gbn_pkg::SEQ_BITS-1:0]   i_seq_in,
    input  logic [gbn_pkg::PAYLOAD_DEF-1:0] i_payload_in,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [1:0]                     i_kind,
    input  logic [gbn_pkg::SEQ_BITS-1:0]   i_seq_out,
    input  logic [gbn_pkg::PAYLOAD_DEF-1:0] i_payload_out,
    input  logic                           i_last,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import gbn_pkg::*;

    localparam int TMR_BITS = TIMER_DEF;
    localparam logic [TMR_BITS-1:0] TMR_SAT = '1;

    typedef struct packed {
        logic [1:0]             kind;
        logic [SEQ_BITS-1:0]    seq;
        logic [PAYLOAD_DEF-1:0] payload;
        logic                   last;
    } t_link_result;

    t_link_result expected_q[$];

    logic [CFG_BITS-1:0]    timeout_ticks;
    logic [SEQ_BITS-1:0]    tx_next_seq;
    logic [SEQ_BITS-1:0]    tx_base_seq;
    logic [CNT_BITS-1:0]    tx_count;
    logic [SEQ_BITS-1:0]    rx_last_seq;
    logic [PAYLOAD_DEF-1:0] window_payload [SEQ_NUM];
    logic [TMR_BITS-1:0]    slot_age [SEQ_NUM];

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    function automatic t_link_result make_result(input logic [1:0] kind,
                                                 input logic [SEQ_BITS-1:0] seq,
                                                 input logic [PAYLOAD_DEF-1:0] payload);
        t_link_result r;
        r.kind    = kind;
        r.seq     = seq;
        r.payload = payload;
        r.last    = 1'b0;
        return r;
    endfunction

    task automatic predict_request(input logic [1:0] op, input logic [SEQ_BITS-1:0] seq,
                                   input logic [PAYLOAD_DEF-1:0] pay);
        t_link_result        res[$];
        t_link_result        r;
        logic                fire;
        logic [SEQ_BITS-1:0] s;
        logic [SEQ_BITS-1:0] ack_gap;
        fire = 1'b0;
        case (op)
            OP_TICK: begin
                // only outstanding slots age
                for (int i = 0; i < tx_count; i++) begin
                    s = SEQ_BITS'(tx_base_seq + i);
                    if (slot_age[s] != TMR_SAT) slot_age[s]++;
                    if (slot_age[s] > timeout_ticks) fire = 1'b1;
                end
                if (fire) begin
                    for (int i = 0; i < tx_count; i++) begin
                        s = SEQ_BITS'(tx_base_seq + i);
                        slot_age[s] = '0;
                        res.push_back(make_result(KIND_DATA, s, window_payload[s]));
                    end
                end
            end
            OP_SEND: begin
                if (tx_count >= WINDOW_DEF) begin
                    res.push_back(make_result(KIND_REFUSE, tx_next_seq, pay));
                end else begin
                    window_payload[tx_next_seq] = pay;
                    slot_age[tx_next_seq] = '0;
                    res.push_back(make_result(KIND_DATA, tx_next_seq, pay));
                    tx_count++;
                    tx_next_seq++;
                end
            end
            OP_ACK: begin
                // cumulative: frees oldest through seq, if seq is outstanding
                ack_gap = SEQ_BITS'(seq - tx_base_seq);
                if (CNT_BITS'(ack_gap) < tx_count) begin
                    tx_base_seq = SEQ_BITS'(tx_base_seq + ack_gap + 1);
                    tx_count    = CNT_BITS'(tx_count - ack_gap - 1);
                end
            end
            default: begin
                if (seq == SEQ_BITS'(rx_last_seq + 1)) begin
                    rx_last_seq = seq;
                    res.push_back(make_result(KIND_DELIVER, seq, pay));
                    res.push_back(make_result(KIND_ACK, seq, '0));
                end else if (seq == rx_last_seq) begin
                    res.push_back(make_result(KIND_ACK, seq, '0));
                end
            end
        endcase
        for (int k = 0; k < res.size(); k++) begin
            r = res[k];
            r.last = (k == res.size() - 1);
            expected_q.push_back(r);
        end
    endtask

    task automatic check_result();
        t_link_result want;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d seq %0d payload %h last %0d",
                                      i_kind, i_seq_out, i_payload_out, i_last));
        end else begin
            want = expected_q.pop_front();
            if (i_kind !== want.kind)
                report_mismatch($sformatf("kind got %0d expected %0d", i_kind, want.kind));
            if (i_seq_out !== want.seq)
                report_mismatch($sformatf("seq got %0d expected %0d", i_seq_out, want.seq));
            if (i_payload_out !== want.payload)
                report_mismatch($sformatf("payload got %h expected %h",
                                          i_payload_out, want.payload));
            if (i_last !== want.last)
                report_mismatch($sformatf("last got %0d expected %0d", i_last, want.last));
            o_checked++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_q.delete();
            timeout_ticks = TIMEOUT_RST;
            tx_next_seq   = '0;
            tx_base_seq   = '0;
            tx_count      = '0;
            rx_last_seq   = RX_SEQ_RST;
            for (int i = 0; i < SEQ_NUM; i++) begin
                window_payload[i] = '0;
                slot_age[i]       = '0;
            end
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_out_valid && !i_out_stall) check_result();
            if (i_cfg_we) timeout_ticks = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) predict_request(i_operation, i_seq_in, i_payload_in);
        end
        o_pending = expected_q.size();
    end

endmodule

// ===== bench/tb_go_back_n_arq_link_core.sv =====
module tb_go_back_n_arq_link_core;
    timeunit 1ns;
    timeprecision 1ps;

    import gbn_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 43;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_cfg_we     = 1'b0;
    logic [CFG_BITS-1:0]    i_cfg_wdata  = '0;
    logic                   i_in_valid   = 1'b0;
    logic [1:0]             i_operation  = OP_TICK;
    logic [SEQ_BITS-1:0]    i_seq_in     = '0;
    logic [PAYLOAD_DEF-1:0] i_payload_in = '0;
    logic                   i_out_stall  = 1'b0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [1:0]             o_kind;
    logic [SEQ_BITS-1:0]    o_seq_out;
    logic [PAYLOAD_DEF-1:0] o_payload_out;
    logic                   o_last;

    int fail_count;
    int pending;
    int checked;

    int                  cycle_count = 0;
    int                  op_count [4];
    int                  settings_count = 0;
    logic                no_gaps = 1'b0;
    logic [SEQ_BITS-1:0] rx_next_seq = '0;
    int                  stall_left = 0;
    int                  stall_pick;
    logic                stall_level = 1'b0;
    logic [CFG_BITS-1:0] phase_timeout [PHASES];

    go_back_n_arq_link_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_seq_in      (i_seq_in),
        .i_payload_in  (i_payload_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_seq_out     (o_seq_out),
        .o_payload_out (o_payload_out),
        .o_last        (o_last)
    );

    gbn_link_checker link_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_seq_in      (i_seq_in),
        .i_payload_in  (i_payload_in),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_kind        (o_kind),
        .i_seq_out     (o_seq_out),
        .i_payload_out (o_payload_out),
        .i_last        (o_last),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
            $display("Verification failed");
            $finish;
        end
    end

    // result side back-pressure: runs of ready, short stalls, the odd long one
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_pick = $urandom_range(99);
            if (stall_pick < 55) begin
                stall_level = 1'b0;
                stall_left  = $urandom_range(20, 1);
            end else if (stall_pick < 93) begin
                stall_level = 1'b1;
                stall_left  = $urandom_range(3, 1);
            end else begin
                stall_level = 1'b1;
                stall_left  = $urandom_range(30, 8);
            end
        end
        stall_left--;
        i_out_stall <= stall_level;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    task automatic push_request(input logic [1:0] op, input logic [SEQ_BITS-1:0] seq,
                                input logic [PAYLOAD_DEF-1:0] pay);
        int gap;
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_seq_in     <= seq;
        i_payload_in <= pay;
        do @(posedge i_clk); while (o_in_stall);
        op_count[op]++;
        if (op == OP_DATA && seq == rx_next_seq) rx_next_seq++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // drain everything, then allow for a tick still walking the timers
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic write_timeout(input logic [CFG_BITS-1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        settings_count++;
    endtask

    task automatic random_request();
        int                  r;
        logic [1:0]          op;
        logic [SEQ_BITS-1:0] seq;
        r   = $urandom_range(99);
        seq = SEQ_BITS'($urandom_range(3));
        if (r < 30)      op = OP_TICK;
        else if (r < 60) op = OP_SEND;
        else if (r < 78) op = OP_ACK;
        else             op = OP_DATA;
        // mostly in-order data frames so the receiver keeps advancing
        if (op == OP_DATA && $urandom_range(99) < 70) seq = rx_next_seq;
        push_request(op, seq, PAYLOAD_DEF'($urandom));
    endtask

    initial begin
        for (int i = 0; i < 4; i++) op_count[i] = 0;
        phase_timeout[0] = '0;
        phase_timeout[1] = CFG_BITS'(1);
        phase_timeout[2] = CFG_BITS'(2);
        phase_timeout[3] = CFG_BITS'(5);
        phase_timeout[4] = CFG_BITS'($urandom_range(40, 3));
        phase_timeout[5] = '1;
        phase_timeout[6] = CFG_BITS'($urandom_range(16777215, 1));

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: receiver cases, window fill and refusal, acks, resends
        push_request(OP_TICK, 2'd0, 16'h0000);
        push_request(OP_DATA, 2'd0, 16'hFFFF);
        push_request(OP_DATA, 2'd0, 16'h1234);
        push_request(OP_DATA, 2'd2, 16'hBEEF);
        push_request(OP_DATA, 2'd1, 16'h0000);
        push_request(OP_SEND, 2'd3, 16'h0000);
        push_request(OP_SEND, 2'd0, 16'hFFFF);
        push_request(OP_SEND, 2'd1, 16'hAAAA);
        push_request(OP_SEND, 2'd2, 16'h5555);
        push_request(OP_SEND, 2'd3, 16'h0F0F);
        push_request(OP_TICK, 2'd0, 16'h0000);
        push_request(OP_ACK,  2'd1, 16'h0000);
        push_request(OP_ACK,  2'd1, 16'hFFFF);
        push_request(OP_ACK,  2'd0, 16'h0000);
        write_timeout('0);
        push_request(OP_TICK, 2'd3, 16'h0000);
        push_request(OP_ACK,  2'd3, 16'h0000);
        push_request(OP_TICK, 2'd0, 16'h0000);
        push_request(OP_SEND, 2'd0, 16'hFFFF);
        write_timeout(CFG_BITS'(1));
        push_request(OP_TICK, 2'd0, 16'h0000);
        push_request(OP_TICK, 2'd0, 16'h0000);
        push_request(OP_DATA, 2'd3, 16'h8001);
        push_request(OP_DATA, 2'd2, 16'hFFFF);
        push_request(OP_ACK,  2'd0, 16'h0000);
        write_timeout('1);
        push_request(OP_SEND, 2'd1, 16'h7FFE);
        push_request(OP_TICK, 2'd0, 16'h0000);

        for (int ph = 0; ph < PHASES; ph++) begin
            write_timeout(phase_timeout[ph]);
            no_gaps = ($urandom_range(2) == 0);
            repeat (PHASE_ITEMS) random_request();
        end

        wait_idle();
        repeat (20) @(negedge i_clk);

        $display("run covered %0d requests: %0d ticks, %0d sends, %0d acks, %0d data frames",
                 op_count[OP_TICK] + op_count[OP_SEND] + op_count[OP_ACK] + op_count[OP_DATA],
                 op_count[OP_TICK], op_count[OP_SEND], op_count[OP_ACK], op_count[OP_DATA]);
        $display("%0d results compared across %0d timeout settings, %0d mismatches",
                 checked, settings_count + 1, fail_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/gbn_pkg.sv
design/gbn_tmr_unit.sv
design/go_back_n_arq_link_core.sv
bench/gbn_link_checker.sv
bench/tb_go_back_n_arq_link_core.sv
